[hw/rtl/nir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_pkg
// Types and timing windows shared by the NEC IR frame decoder.
// ----------------------------------------------------------------------------
package nir_pkg;

   localparam int DUR_W   = 16;
   localparam int CODE_W  = 32;
   localparam int COUNT_W = 6;
   localparam int POS_W   = 7;

   localparam logic [POS_W-1:0] POS_MAX = 7'd127;

   // Timing in microseconds; captured durations are in ticks.
   localparam int TICK_US       = 50;
   localparam int EXCESS_US     = 100;
   localparam int TOL_PCT       = 25;
   localparam int HDR_MARK_US   = 9000;
   localparam int HDR_SPACE_US  = 4500;
   localparam int BIT_MARK_US   = 560;
   localparam int ONE_SPACE_US  = 1600;
   localparam int ZERO_SPACE_US = 560;
   localparam int RPT_SPACE_US  = 2250;

   localparam int LoScale = 100 - TOL_PCT;
   localparam int HiScale = 100 + TOL_PCT;
   localparam int Div     = 100 * TICK_US;

   // Marks run long by the excess, spaces run short by it.
   localparam logic [DUR_W-1:0] HDR_MARK_LO =
      16'((HDR_MARK_US + EXCESS_US) * LoScale / Div);
   localparam logic [DUR_W-1:0] HDR_MARK_HI =
      16'((HDR_MARK_US + EXCESS_US) * HiScale / Div + 1);
   localparam logic [DUR_W-1:0] HDR_SPACE_LO =
      16'((HDR_SPACE_US - EXCESS_US) * LoScale / Div);
   localparam logic [DUR_W-1:0] HDR_SPACE_HI =
      16'((HDR_SPACE_US - EXCESS_US) * HiScale / Div + 1);
   localparam logic [DUR_W-1:0] BIT_MARK_LO =
      16'((BIT_MARK_US + EXCESS_US) * LoScale / Div);
   localparam logic [DUR_W-1:0] BIT_MARK_HI =
      16'((BIT_MARK_US + EXCESS_US) * HiScale / Div + 1);
   localparam logic [DUR_W-1:0] ONE_SPACE_LO =
      16'((ONE_SPACE_US - EXCESS_US) * LoScale / Div);
   localparam logic [DUR_W-1:0] ONE_SPACE_HI =
      16'((ONE_SPACE_US - EXCESS_US) * HiScale / Div + 1);
   localparam logic [DUR_W-1:0] ZERO_SPACE_LO =
      16'((ZERO_SPACE_US - EXCESS_US) * LoScale / Div);
   localparam logic [DUR_W-1:0] ZERO_SPACE_HI =
      16'((ZERO_SPACE_US - EXCESS_US) * HiScale / Div + 1);
   localparam logic [DUR_W-1:0] RPT_SPACE_LO =
      16'((RPT_SPACE_US - EXCESS_US) * LoScale / Div);
   localparam logic [DUR_W-1:0] RPT_SPACE_HI =
      16'((RPT_SPACE_US - EXCESS_US) * HiScale / Div + 1);

   typedef enum logic [1:0] {
      STATUS_ERROR  = 2'd0,
      STATUS_DATA   = 2'd1,
      STATUS_REPEAT = 2'd2
   } status_type;

   typedef struct packed {
      logic [DUR_W-1:0] duration;
      logic             frame_end;
   } req_word_type;

   typedef struct packed {
      status_type         status;
      logic [CODE_W-1:0]  code_value;
      logic [COUNT_W-1:0] bit_count;
   } rsp_word_type;

   typedef struct packed {
      logic hdr_mark;
      logic hdr_space;
      logic bit_mark;
      logic one_space;
      logic zero_space;
      logic rpt_space;
   } win_flags_type;

endpackage

[hw/rtl/nir_in_reg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_in_reg
// Input register: holds one duration word until the decoder takes it.
// ----------------------------------------------------------------------------
module nir_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nir_pkg::req_word_type req_word,
   input  logic                  advance,
   output logic                  in_valid,
   output nir_pkg::req_word_type in_word
);

   logic                  valid_ff, valid_in;
   nir_pkg::req_word_type word_ff;

   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         word_ff <= req_word;
      end
   end

   assign in_valid = valid_ff;
   assign in_word  = word_ff;

endmodule

[hw/rtl/nir_win_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_win_check
// Compares one duration against every NEC timing window.
// ----------------------------------------------------------------------------
module nir_win_check (
   input  logic [nir_pkg::DUR_W-1:0] duration,
   output nir_pkg::win_flags_type    flags
);

   always_comb begin
      flags.hdr_mark   = duration >= nir_pkg::HDR_MARK_LO   && duration <= nir_pkg::HDR_MARK_HI;
      flags.hdr_space  = duration >= nir_pkg::HDR_SPACE_LO  && duration <= nir_pkg::HDR_SPACE_HI;
      flags.bit_mark   = duration >= nir_pkg::BIT_MARK_LO   && duration <= nir_pkg::BIT_MARK_HI;
      flags.one_space  = duration >= nir_pkg::ONE_SPACE_LO  && duration <= nir_pkg::ONE_SPACE_HI;
      flags.zero_space = duration >= nir_pkg::ZERO_SPACE_LO && duration <= nir_pkg::ZERO_SPACE_HI;
      flags.rpt_space  = duration >= nir_pkg::RPT_SPACE_LO  && duration <= nir_pkg::RPT_SPACE_HI;
   end

endmodule

[hw/rtl/nir_frame_ctl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_frame_ctl
// Frame state (position, shift data, check flags) and the result register.
// ----------------------------------------------------------------------------
module nir_frame_ctl #(
   parameter int CODE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  nir_pkg::req_word_type  in_word,
   input  nir_pkg::win_flags_type flags,
   output logic                   advance,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output nir_pkg::rsp_word_type  rsp_word
);

   localparam logic [nir_pkg::POS_W-1:0] LastBitPos  = 7'(2 * CODE_BITS + 2);
   localparam logic [nir_pkg::POS_W-1:0] MinDataLast = 7'(2 * CODE_BITS + 3);

   logic [nir_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [nir_pkg::CODE_W-1:0] shift_ff, shift_in;
   logic                       err_ff, err_in;
   logic                       rso_ff, rso_in;
   logic                       rmo_ff, rmo_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   nir_pkg::rsp_word_type      rsp_word_ff, rsp_word_in;
   logic [nir_pkg::POS_W-1:0]  pos_step;
   logic                       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign advance  = in_valid && (!in_word.frame_end || out_free);

   always_comb begin
      err_in   = err_ff;
      rso_in   = rso_ff;
      rmo_in   = rmo_ff;
      shift_in = shift_ff;
      if (pos_ff == 7'd1) begin
         if (!flags.hdr_mark) err_in = 1'b1;
      end else if (pos_ff == 7'd2) begin
         rso_in = !err_ff && flags.rpt_space;
         if (!flags.hdr_space) err_in = 1'b1;
      end else if (pos_ff >= 7'd3 && pos_ff <= LastBitPos) begin
         if (pos_ff == 7'd3) rmo_in = flags.bit_mark;
         // odd entries are bit marks, even entries carry the bit in the space
         priority if (pos_ff[0]) begin
            if (!flags.bit_mark) err_in = 1'b1;
         end else if (flags.one_space) begin
            shift_in = {shift_ff[nir_pkg::CODE_W-2:0], 1'b1};
         end else if (flags.zero_space) begin
            shift_in = {shift_ff[nir_pkg::CODE_W-2:0], 1'b0};
         end else begin
            err_in = 1'b1;
         end
      end
      pos_step = (pos_ff < nir_pkg::POS_MAX) ? pos_ff + 7'd1 : pos_ff;
      pos_in   = pos_step;

      rsp_word_in.status     = nir_pkg::STATUS_ERROR;
      rsp_word_in.code_value = '0;
      rsp_word_in.bit_count  = '0;
      if (pos_ff == 7'd3 && rso_in && rmo_in) begin
         rsp_word_in.status     = nir_pkg::STATUS_REPEAT;
         rsp_word_in.code_value = '1;
      end else if (pos_ff >= MinDataLast && !err_in) begin
         rsp_word_in.status     = nir_pkg::STATUS_DATA;
         rsp_word_in.code_value = shift_in;
         rsp_word_in.bit_count  = 6'(CODE_BITS);
      end

      // end of frame: start clean for the next one
      if (in_word.frame_end) begin
         pos_in   = '0;
         shift_in = '0;
         err_in   = 1'b0;
         rso_in   = 1'b0;
         rmo_in   = 1'b0;
      end

      if (advance && in_word.frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         shift_ff     <= '0;
         err_ff       <= 1'b0;
         rso_ff       <= 1'b0;
         rmo_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            pos_ff   <= pos_in;
            shift_ff <= shift_in;
            err_ff   <= err_in;
            rso_ff   <= rso_in;
            rmo_ff   <= rmo_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_word.frame_end) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

[hw/rtl/nec_ir_frame_decoder_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_top
// NEC IR frame decoder: one captured duration in, one result per frame out.
//
// req_*: one word per captured mark or space, in 50 us ticks; frame_end flags
// the last word of a frame. The first word of each frame (the gap) is skipped.
// rsp_*: one word per frame: status, 32-bit code and bit count.
// Throughput: one req word per cycle while rsp keeps up. Words that do not
// end a frame are taken every cycle even while a result waits.
// Path: a frame_end word is held in the input register, then its result is
// registered in the result register once that register is free.
// Stall: while rsp_ready is low a waiting result holds; a frame_end word then
// waits in the input register and req_ready drops until the result leaves.
// Reset: clears frame state and both valid flags; the next word starts a
// new frame.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top #(
   parameter int CODE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  nir_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output nir_pkg::rsp_word_type rsp_word
);

   logic                   advance;
   logic                   in_valid;
   nir_pkg::req_word_type  in_word;
   nir_pkg::win_flags_type flags;

   nir_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .advance   (advance),
      .in_valid  (in_valid),
      .in_word   (in_word)
   );

   nir_win_check u_win_check (
      .duration (in_word.duration),
      .flags    (flags)
   );

   nir_frame_ctl #(
      .CODE_BITS (CODE_BITS)
   ) u_frame_ctl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .in_word   (in_word),
      .flags     (flags),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

endmodule

[hw/rtl/nir_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nir_checker
// Port-level checks on the NEC IR frame decoder result channel.
// ----------------------------------------------------------------------------
module nir_checker #(
   parameter int CODE_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input nir_pkg::rsp_word_type rsp_word
);

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_data_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == nir_pkg::STATUS_DATA
         |-> rsp_word.bit_count == 6'(CODE_BITS))
      else $error("data word with wrong bit count");

   a_repeat_word : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == nir_pkg::STATUS_REPEAT
         |-> rsp_word.code_value == '1 && rsp_word.bit_count == '0)
      else $error("malformed repeat word");

   a_error_word : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status == nir_pkg::STATUS_ERROR
         |-> rsp_word.code_value == '0 && rsp_word.bit_count == '0)
      else $error("malformed error word");

   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind nec_ir_frame_decoder_top nir_checker #(
   .CODE_BITS (CODE_BITS)
) u_nir_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

[verif/nec_ir_frame_decoder_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder_top_test
// Self-checking bench for the NEC IR frame decoder. A short table of frames
// covers window edges, short frames, repeats and failed repeats. Random
// frames follow: mostly well-formed data and repeat frames, some with a
// flawed entry, plus truncated, overlong and noise frames. Every result word
// is checked against the table's expected word or an in-bench decoder model,
// under bursty input and random output stalls.
// ----------------------------------------------------------------------------
module nec_ir_frame_decoder_top_test;

   localparam int CODE_BITS      = 32;
   localparam int LAST_BIT_POS   = 2 * CODE_BITS + 2;
   localparam int DATA_FRAME_LEN = 2 * CODE_BITS + 4;
   localparam int RANDOM_WORDS   = 900;
   localparam int MIN_FRAMES     = 36;
   localparam int LONG_HOLD      = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIR_ROWS       = 27;

   // tick windows
   localparam int HDR_MARK_MIN   = 136;
   localparam int HDR_MARK_MAX   = 228;
   localparam int HDR_SPACE_MIN  = 66;
   localparam int HDR_SPACE_MAX  = 111;
   localparam int BIT_MARK_MIN   = 9;
   localparam int BIT_MARK_MAX   = 17;
   localparam int ONE_SPACE_MIN  = 22;
   localparam int ONE_SPACE_MAX  = 38;
   localparam int ZERO_SPACE_MIN = 6;
   localparam int ZERO_SPACE_MAX = 12;
   localparam int RPT_SPACE_MIN  = 32;
   localparam int RPT_SPACE_MAX  = 54;

   typedef struct packed {
      logic [nir_pkg::DUR_W-1:0]   dur;
      logic                        last;
      logic                        known;
      nir_pkg::status_type         status;
      logic [nir_pkg::CODE_W-1:0]  code;
      logic [nir_pkg::COUNT_W-1:0] bits;
   } dir_row_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   nir_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   nir_pkg::rsp_word_type rsp_word;

   // typed expectation travelling with the word on the req side
   logic                  tag_known  = 1'b0;
   nir_pkg::rsp_word_type tag_expect = '0;

   // decoder model state
   logic [nir_pkg::POS_W-1:0]  frame_pos      = '0;
   logic [nir_pkg::CODE_W-1:0] code_shift     = '0;
   logic                       frame_bad      = 1'b0;
   logic                       rpt_space_good = 1'b0;
   logic                       rpt_mark_good  = 1'b0;

   nir_pkg::rsp_word_type pending_results [$];
   nir_pkg::req_word_type frame_words [$];
   dir_row_type           dir_table [0:DIR_ROWS-1];

   int   fail_count   = 0;
   int   stall_cycles = 0;
   int   words_sent   = 0;
   int   frames_sent  = 0;
   int   burst_left   = 0;
   logic hold_go      = 1'b0;

   nec_ir_frame_decoder_top #(
      .CODE_BITS(CODE_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_word (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic fits(input logic [nir_pkg::DUR_W-1:0] d, input int lo,
                                 input int hi);
      return d >= lo && d <= hi;
   endfunction

   // Advances the frame model by one word; returns 1 when the word ends a frame.
   function automatic bit ir_decode_step(input nir_pkg::req_word_type w,
                                         output nir_pkg::rsp_word_type r);
      logic [nir_pkg::DUR_W-1:0] d;
      logic [nir_pkg::POS_W-1:0] p;
      int                        frame_len;
      d = w.duration;
      p = frame_pos;
      r = '0;
      if (p == 1) begin
         if (!fits(d, HDR_MARK_MIN, HDR_MARK_MAX)) frame_bad = 1'b1;
      end else if (p == 2) begin
         rpt_space_good = !frame_bad && fits(d, RPT_SPACE_MIN, RPT_SPACE_MAX);
         if (!fits(d, HDR_SPACE_MIN, HDR_SPACE_MAX)) frame_bad = 1'b1;
      end else if (p >= 3 && p <= LAST_BIT_POS) begin
         if (p == 3) rpt_mark_good = fits(d, BIT_MARK_MIN, BIT_MARK_MAX);
         if (p[0]) begin
            if (!fits(d, BIT_MARK_MIN, BIT_MARK_MAX)) frame_bad = 1'b1;
         end else if (fits(d, ONE_SPACE_MIN, ONE_SPACE_MAX)) begin
            code_shift = {code_shift[nir_pkg::CODE_W-2:0], 1'b1};
         end else if (fits(d, ZERO_SPACE_MIN, ZERO_SPACE_MAX)) begin
            code_shift = {code_shift[nir_pkg::CODE_W-2:0], 1'b0};
         end else begin
            frame_bad = 1'b1;
         end
      end
      if (frame_pos != nir_pkg::POS_MAX) frame_pos = frame_pos + 1'b1;
      if (!w.frame_end) return 1'b0;
      frame_len = p + 1;
      if (frame_len == 4 && rpt_space_good && rpt_mark_good) begin
         r.status     = nir_pkg::STATUS_REPEAT;
         r.code_value = '1;
      end else if (frame_len >= DATA_FRAME_LEN && !frame_bad) begin
         r.status     = nir_pkg::STATUS_DATA;
         r.code_value = code_shift;
         r.bit_count  = nir_pkg::COUNT_W'(CODE_BITS);
      end else begin
         r.status = nir_pkg::STATUS_ERROR;
      end
      frame_pos      = '0;
      code_shift     = '0;
      frame_bad      = 1'b0;
      rpt_space_good = 1'b0;
      rpt_mark_good  = 1'b0;
      return 1'b1;
   endfunction

   // Value inside the window, or just outside / far outside when flawed.
   function automatic logic [nir_pkg::DUR_W-1:0] pick(input int lo, input int hi,
                                                      input bit flawed);
      if (!flawed) return nir_pkg::DUR_W'($urandom_range(hi, lo));
      case ($urandom_range(0, 2))
         0: return nir_pkg::DUR_W'(lo - 1);
         1: return nir_pkg::DUR_W'(hi + 1);
         default: return nir_pkg::DUR_W'($urandom_range(65535, hi + 1));
      endcase
   endfunction

   function automatic void build_frame(input int len, input bit as_repeat, input bit noise,
                                       input int flaw_at);
      logic [nir_pkg::CODE_W-1:0] code;
      nir_pkg::req_word_type      w;
      bit                         f;
      int                         i;
      code = $urandom;
      frame_words.delete();
      for (i = 0; i < len; i++) begin
         f = (i == flaw_at);
         if (noise) begin
            w.duration = $urandom_range(0, 1)
                            ? nir_pkg::DUR_W'($urandom_range(0, 65535))
                            : nir_pkg::DUR_W'($urandom_range(0, 250));
         end else if (i == 0 || i > LAST_BIT_POS) begin
            w.duration = nir_pkg::DUR_W'($urandom_range(0, 65535));
         end else if (i == 1) begin
            w.duration = pick(HDR_MARK_MIN, HDR_MARK_MAX, f);
         end else if (i == 2) begin
            w.duration = as_repeat ? pick(RPT_SPACE_MIN, RPT_SPACE_MAX, f)
                                   : pick(HDR_SPACE_MIN, HDR_SPACE_MAX, f);
         end else if (i % 2 == 1) begin
            w.duration = pick(BIT_MARK_MIN, BIT_MARK_MAX, f);
         end else if (code[nir_pkg::CODE_W - 1 - (i - 4) / 2]) begin
            w.duration = pick(ONE_SPACE_MIN, ONE_SPACE_MAX, f);
         end else begin
            w.duration = pick(ZERO_SPACE_MIN, ZERO_SPACE_MAX, f);
         end
         w.frame_end = (i == len - 1);
         frame_words.push_back(w);
      end
   endfunction

   // Offers one word; sender runs in bursts with idle gaps between them.
   task automatic offer(input nir_pkg::req_word_type w, input logic known,
                        input nir_pkg::rsp_word_type exp);
      if (burst_left == 0) begin
         if (req_valid) req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 16);
      end
      req_word   <= w;
      tag_known  <= known;
      tag_expect <= exp;
      req_valid  <= 1'b1;
      burst_left--;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      if (w.frame_end) frames_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // scoreboard: predicts on accepted req words, checks accepted rsp words
   always @(posedge clock) begin : scoreboard
      nir_pkg::rsp_word_type want;
      nir_pkg::rsp_word_type predicted;
      bit                    produced;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles = 0;
         else stall_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: status=%0d code=%h bits=%0d",
                           rsp_word.status, rsp_word.code_value, rsp_word.bit_count);
            end else begin
               want = pending_results.pop_front();
               if (rsp_word.status !== want.status || rsp_word.code_value !== want.code_value
                   || rsp_word.bit_count !== want.bit_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"mismatch: expected status=%0d code=%h bits=%0d, ",
                               "got status=%0d code=%h bits=%0d"},
                              want.status, want.code_value, want.bit_count,
                              rsp_word.status, rsp_word.code_value, rsp_word.bit_count);
               end
            end
         end
         if (req_valid && req_ready) begin
            produced = ir_decode_step(req_word, predicted);
            if (produced) pending_results.push_back(tag_known ? tag_expect : predicted);
         end
      end
   end

   // receiver: stall patterns that change every so often, plus one long hold
   initial begin : receiver
      int  mode;
      int  mode_left;
      int  phase;
      bit  hold_done;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_done = 1'b1;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         phase++;
         case (mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            2: rsp_ready <= (phase % 4 == 0);
            default: rsp_ready <= ($urandom_range(0, 9) != 0);
         endcase
      end
   end

   initial begin : watchdog
      while (stall_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("nec_ir_frame_decoder_top_test: errors");
      $finish;
   end

   initial begin : stimulus
      nir_pkg::req_word_type w;
      nir_pkg::rsp_word_type exp;
      int                    i;
      int                    kind;
      int                    len;
      int                    flaw;
      bit                    mid_pause_done;
      mid_pause_done = 1'b0;
      dir_table = '{
         // single-entry frame
         '{16'd0,     1'b1, 1'b1, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         // two entries, gap at max then header mark at top of window
         '{16'd65535, 1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd228,   1'b1, 1'b1, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         // three entries
         '{16'd0,     1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd136,   1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd66,    1'b1, 1'b1, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         // repeat, every window at its low edge
         '{16'd65535, 1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd136,   1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd32,    1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd9,     1'b1, 1'b1, nir_pkg::STATUS_REPEAT, 32'hFFFFFFFF, 6'd0},
         // repeat, every window at its high edge
         '{16'd0,     1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd228,   1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd54,    1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd17,    1'b1, 1'b1, nir_pkg::STATUS_REPEAT, 32'hFFFFFFFF, 6'd0},
         // failed repeat: header mark one tick short
         '{16'd5,     1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd135,   1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd40,    1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd10,    1'b1, 1'b1, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         // failed repeat: repeat space one tick long
         '{16'd5,     1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd150,   1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd55,    1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd12,    1'b1, 1'b1, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         // five entries: too long for a repeat, too short for data
         '{16'd1,     1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd150,   1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd80,    1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd12,    1'b0, 1'b0, nir_pkg::STATUS_ERROR,  32'h0,        6'd0},
         '{16'd30,    1'b1, 1'b1, nir_pkg::STATUS_ERROR,  32'h0,        6'd0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         w.duration       = dir_table[i].dur;
         w.frame_end      = dir_table[i].last;
         exp.status       = dir_table[i].status;
         exp.code_value   = dir_table[i].code;
         exp.bit_count    = dir_table[i].bits;
         offer(w, dir_table[i].known, exp);
      end
      drain_results();

      words_sent  = 0;
      frames_sent = 0;
      while (words_sent < RANDOM_WORDS || frames_sent < MIN_FRAMES) begin
         if (words_sent > 200) hold_go <= 1'b1;
         if (!mid_pause_done && frames_sent >= MIN_FRAMES / 2) begin
            drain_results();
            mid_pause_done = 1'b1;
         end
         kind = $urandom_range(0, 9);
         flaw = -1;
         case (kind)
            0, 1, 2: begin
               len = ($urandom_range(0, 9) == 0) ? $urandom_range(DATA_FRAME_LEN + 1, 140)
                                                 : DATA_FRAME_LEN;
               if ($urandom_range(0, 3) == 0) flaw = $urandom_range(1, LAST_BIT_POS);
               build_frame(len, 1'b0, 1'b0, flaw);
            end
            3, 4, 5, 6: begin
               if ($urandom_range(0, 3) == 0) flaw = $urandom_range(1, 3);
               build_frame(4, 1'b1, 1'b0, flaw);
            end
            7: build_frame($urandom_range(1, 10), 1'b0, 1'b1, -1);
            8: build_frame($urandom_range(5, DATA_FRAME_LEN - 1), 1'b0, 1'b0, -1);
            default: build_frame($urandom_range(60, 75), 1'b0, 1'b1, -1);
         endcase
         foreach (frame_words[j]) offer(frame_words[j], 1'b0, '0);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("nec_ir_frame_decoder_top_test: clean");
      end else begin
         $display("nec_ir_frame_decoder_top_test: errors");
      end
      $finish;
   end

endmodule

[sim.f]
hw/rtl/nir_pkg.sv
hw/rtl/nir_in_reg.sv
hw/rtl/nir_win_check.sv
hw/rtl/nir_frame_ctl.sv
hw/rtl/nec_ir_frame_decoder_top.sv
hw/rtl/nir_checker.sv
verif/nec_ir_frame_decoder_top_test.sv
